/* rtl/spk_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spk_pkg
// Shared constants and types for the round-reduced Speck64/128 encryptor.
// ----------------------------------------------------------------------------
package spk_pkg;

    localparam int WORD_W     = 32;
    localparam int ROUND_W    = 5;
    localparam int MAX_ROUNDS = 27;
    localparam int ROT_X      = 8;
    localparam int ROT_Y      = 3;

    localparam logic [ROUND_W-1:0] MAX_ROUNDS_C = ROUND_W'(MAX_ROUNDS);

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        word_t x;
        word_t y;
        word_t k;
        word_t l0;
        word_t l1;
        word_t l2;
    } spk_state_t;

    function automatic word_t rotr(input word_t v, input int unsigned n);
        rotr = (v >> n) | (v << (WORD_W - n));
    endfunction

    function automatic word_t rotl(input word_t v, input int unsigned n);
        rotl = (v << n) | (v >> (WORD_W - n));
    endfunction

endpackage
`default_nettype wire

/* rtl/spk_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spk_cell
// One round of the chain: data round and key schedule step, registered.
// Passes the state through unchanged when its index is not below the count.
// ----------------------------------------------------------------------------
module spk_cell
    import spk_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [ROUND_W-1:0] round_idx,
    input  wire logic [ROUND_W-1:0] round_count,
    input  wire logic               in_valid,
    input  wire spk_state_t         in_state,
    output logic                    out_valid,
    output spk_state_t              out_state
);

    logic       valid_reg;
    spk_state_t state_reg;
    spk_state_t state_next;
    word_t      nx;
    word_t      nl;

    always_comb
    begin
        nx = (rotr(in_state.x, ROT_X) + in_state.y) ^ in_state.k;
        nl = (rotr(in_state.l0, ROT_X) + in_state.k) ^ WORD_W'(round_idx);
        if (round_idx < round_count)
        begin
            state_next.x  = nx;
            state_next.y  = rotl(in_state.y, ROT_Y) ^ nx;
            state_next.k  = rotl(in_state.k, ROT_Y) ^ nl;
            state_next.l0 = in_state.l1;
            state_next.l1 = in_state.l2;
            state_next.l2 = nl;
        end
        else
        begin
            state_next = in_state;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;

endmodule
`default_nettype wire

/* rtl/speck64_128_round_reduced_encrypt.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// speck64_128_round_reduced_encrypt
// Speck64/128 encryption with a configurable number of rounds (0 to 27).
// ----------------------------------------------------------------------------
// A plaintext and its key are taken on every cycle that start is high; busy
// stays low. Every item passes through a row of 27 registered round cells,
// so done pulses for one cycle as the item leaves the last cell, with the
// ciphertext on ct_word0/ct_word1, whatever the round count. The receiver
// cannot stall: sample the result in the done cycle. Cells at or beyond the
// round count pass the state through. Write round_count only while no beat
// is in flight; values above 27 saturate to 27.
// ----------------------------------------------------------------------------
module speck64_128_round_reduced_encrypt
    import spk_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [WORD_W-1:0]  pt_word0,
    input  wire logic [WORD_W-1:0]  pt_word1,
    input  wire logic [WORD_W-1:0]  key_word0,
    input  wire logic [WORD_W-1:0]  key_word1,
    input  wire logic [WORD_W-1:0]  key_word2,
    input  wire logic [WORD_W-1:0]  key_word3,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [ROUND_W-1:0] cfg_data,
    output logic                    done,
    output logic [WORD_W-1:0]       ct_word0,
    output logic [WORD_W-1:0]       ct_word1
);

    logic [ROUND_W-1:0] round_count_reg;
    logic [ROUND_W-1:0] round_count_next;
    logic               valid_chain [MAX_ROUNDS+1];
    spk_state_t         state_chain [MAX_ROUNDS+1];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        round_count_next = round_count_reg;
        if (cfg_valid && cfg_ready)
        begin
            round_count_next = (cfg_data > MAX_ROUNDS_C) ? MAX_ROUNDS_C : cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_count_reg <= MAX_ROUNDS_C;
        end
        else
        begin
            round_count_reg <= round_count_next;
        end
    end

    assign valid_chain[0] = start && !busy;
    assign state_chain[0] = '{x:  pt_word1,
                              y:  pt_word0,
                              k:  key_word0,
                              l0: key_word1,
                              l1: key_word2,
                              l2: key_word3};

    for (genvar i = 0; i < MAX_ROUNDS; i++)
    begin : g_cell
        spk_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .round_idx   (ROUND_W'(i)),
            .round_count (round_count_reg),
            .in_valid    (valid_chain[i]),
            .in_state    (state_chain[i]),
            .out_valid   (valid_chain[i+1]),
            .out_state   (state_chain[i+1])
        );
    end

    assign done     = valid_chain[MAX_ROUNDS];
    assign ct_word0 = state_chain[MAX_ROUNDS].y;
    assign ct_word1 = state_chain[MAX_ROUNDS].x;

    a_done_follows_start: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, MAX_ROUNDS)
    ) else $error("result beat without a matching start");

    a_count_saturated: assert property (
        @(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> round_count_reg <= MAX_ROUNDS_C
    ) else $error("round count above maximum");

    a_zero_rounds_pass: assert property (
        @(posedge clk) disable iff (!rst_n)
        done && round_count_reg == '0 && $stable(round_count_reg)
            |-> ct_word0 == $past(pt_word0, MAX_ROUNDS)
             && ct_word1 == $past(pt_word1, MAX_ROUNDS)
    ) else $error("zero-round result differs from plaintext");

endmodule
`default_nettype wire
